/* rtl/core/markup_tag_nesting_tracker_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the markup tag nesting tracker
// ---------------------------------------------------------------------------
`ifndef MARKUP_TAG_NESTING_TRACKER_UNIT_DEFINES_SVH
`define MARKUP_TAG_NESTING_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MTNT_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mtnt assertion failed");

// next-cycle implication, checked out of reset
`define MTNT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mtnt assertion failed");

`endif

/* rtl/core/mtnt_pkg.sv */
// ---------------------------------------------------------------------------
// mtnt_pkg
// Shared types, codes and pattern table of the tag nesting tracker.
// ---------------------------------------------------------------------------
package mtnt_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 3;
  localparam int DEPTH_W     = 7;
  localparam int NPAT        = 15;
  localparam int HIT_W       = 4;
  localparam int WIN_W       = 48;
  localparam int SEQ_W       = WIN_W + BYTE_W;
  localparam int NUM_OPEN    = 7;
  localparam int BARE_CLOSE  = 14;
  localparam int TDATA_OUT_W = 16;

  localparam logic [BYTE_W-1:0] CHAR_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_OTHER = '0;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_PUSH      = 3'd1,
    ACT_POP       = 3'd2,
    ACT_UNMATCHED = 3'd3,
    ACT_FULL      = 3'd4,
    ACT_IGNORED   = 3'd5
  } action_t;

  // result word, tag_kind in the lowest bits
  typedef struct packed {
    kind_t                top_kind;
    logic [DEPTH_W-1:0]   depth;
    action_t              action;
    kind_t                tag_kind;
  } result_t;

  // first character in the highest used byte
  localparam logic [SEQ_W-1:0] PAT_BITS [NPAT] = '{
    56'h3C646976,        // <div
    56'h3C61,            // <a
    56'h3C756C,          // <ul
    56'h3C7374796C65,    // <style
    56'h3C7472,          // <tr
    56'h3C70,            // <p
    56'h3C656D,          // <em
    56'h3C2F646976,      // </div
    56'h3C2F61,          // </a
    56'h3C2F756C,        // </ul
    56'h3C2F7374796C65,  // </style
    56'h3C2F7472,        // </tr
    56'h3C2F70,          // </p
    56'h3C2F656D,        // </em
    56'h3C2F             // </
  };

  localparam int PAT_LEN [NPAT] = '{4, 2, 3, 6, 3, 2, 3, 5, 3, 4, 7, 4, 3, 4, 2};

  // which patterns end at the newest byte of seq
  function automatic logic [NPAT-1:0] match_suffixes(input logic [SEQ_W-1:0] seq);
    logic [SEQ_W-1:0] mask;
    logic [NPAT-1:0]  hits;
    hits = '0;
    for (int i = 0; i < NPAT; i++) begin
      mask    = {SEQ_W{1'b1}} >> (SEQ_W - BYTE_W * PAT_LEN[i]);
      hits[i] = ((seq & mask) == PAT_BITS[i]);
    end
    return hits;
  endfunction

endpackage

/* rtl/core/mtnt_ram.sv */
// ---------------------------------------------------------------------------
// mtnt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mtnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/markup_tag_nesting_tracker_unit.sv */
// ---------------------------------------------------------------------------
// markup_tag_nesting_tracker_unit
// Scans markup bytes and tracks tag nesting on a stack of tag kinds.
// ---------------------------------------------------------------------------
// Input stream: one text byte per request on s_tdata.
// Output stream: one result per input byte. m_tlast marks a '>' that ends
// a tag segment; m_tdata carries tag_kind, action, depth and top_kind.
// m_tvalid rises in the cycle after input acceptance; one byte per cycle
// is sustained while m_tready is high. The top of stack lives in a register
// and the entry below it is read from the stack RAM every cycle, so a pop
// has the new top ready without waiting on the RAM read port.
// When the receiver stalls, the output register holds its result and
// s_tready drops until the result is taken.
// Reset empties the stack, clears the byte window and pattern flags and
// drops m_tvalid. Stack RAM contents are not cleared; data read from
// unwritten entries is never used, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module markup_tag_nesting_tracker_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mtnt_pkg::BYTE_W-1:0]        s_tdata,   // in_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tag_kind[2:0], action[5:3], depth[12:6], top_kind[15:13]
  output logic [mtnt_pkg::TDATA_OUT_W-1:0]   m_tdata,
  output logic                               m_tlast    // tag_end
);

  import mtnt_pkg::*;

  logic                 accept;
  logic [CNT_W-1:0]     count, count_next, count_eff;
  kind_t                top, top_next, below;
  logic [WIN_W-1:0]     window, window_next;
  logic [NPAT-1:0]      seen, seen_next;
  logic [SEQ_W-1:0]     seq;
  logic [HIT_W-1:0]     hit;
  logic                 is_end;
  logic                 do_push, do_pop, we;
  kind_t                kind;
  action_t              act;
  result_t              res, res_next;
  logic                 out_valid, out_last;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !out_valid || m_tready;
  assign seq      = {window, s_tdata};

  // first pattern flag in priority order; NPAT when none
  always_comb begin
    hit = HIT_W'(NPAT);
    for (int i = NPAT - 1; i >= 0; i--) begin
      if (seen[i]) begin
        hit = HIT_W'(i);
      end
    end
  end

  always_comb begin
    count_next  = count;
    top_next    = top;
    window_next = window;
    seen_next   = seen;
    is_end      = 1'b0;
    kind        = KIND_OTHER;
    act         = ACT_NONE;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    we          = 1'b0;

    if (s_tdata != CHAR_GT) begin
      window_next = seq[WIN_W-1:0];
      seen_next   = seen | match_suffixes(seq);
    end else begin
      is_end      = 1'b1;
      window_next = '0;
      seen_next   = '0;
      priority if (hit < HIT_W'(NUM_OPEN)) begin
        kind    = KIND_W'(hit + HIT_W'(1));
        do_push = 1'b1;
      end else if (hit < HIT_W'(BARE_CLOSE)) begin
        kind   = KIND_W'(hit - HIT_W'(NUM_OPEN - 1));
        do_pop = 1'b1;
      end else if (hit == HIT_W'(BARE_CLOSE)) begin
        do_pop = 1'b1;
      end else if (window[BYTE_W-1:0] == CHAR_SLASH) begin
        act = ACT_IGNORED;
      end else begin
        do_push = 1'b1;
      end
    end

    if (do_push) begin
      if (count >= CNT_W'(STACK_DEPTH)) begin
        act = ACT_FULL;
      end else begin
        act        = ACT_PUSH;
        we         = 1'b1;
        count_next = count + CNT_W'(1);
        top_next   = kind;
      end
    end

    if (do_pop) begin
      if (count == '0 || top != kind) begin
        act = ACT_UNMATCHED;
      end else begin
        act        = ACT_POP;
        count_next = count - CNT_W'(1);
        top_next   = below;
      end
    end

    res_next.tag_kind = kind;
    res_next.action   = act;
    res_next.depth    = DEPTH_W'(count_next);
    res_next.top_kind = (count_next == '0) ? KIND_OTHER : top_next;
  end

  // keep the entry below the top on the RAM read port at all times
  assign count_eff = accept ? count_next : count;

  mtnt_ram #(
    .WIDTH (KIND_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (accept && we),
    .waddr (ADDR_W'(count)),
    .wdata (kind),
    .raddr (ADDR_W'(count_eff - CNT_W'(2))),
    .rdata (below)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      window <= '0;
      seen   <= '0;
    end else if (accept) begin
      count  <= count_next;
      window <= window_next;
      seen   <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top      <= top_next;
      res      <= res_next;
      out_last <= is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_OUT_W'(res);
  assign m_tlast  = out_last;

endmodule

/* rtl/core/mtnt_checker.sv */
// ---------------------------------------------------------------------------
// mtnt_checker
// Port-level checks on the tag nesting tracker, bound to its top level.
// ---------------------------------------------------------------------------
`include "markup_tag_nesting_tracker_unit_defines.svh"

module mtnt_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [mtnt_pkg::TDATA_OUT_W-1:0]   m_tdata,
  input logic                               m_tlast
);

  import mtnt_pkg::*;

  result_t r;
  assign r = result_t'(m_tdata);

  // stalled result holds
  `MTNT_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // every accepted request yields a result on the next cycle
  `MTNT_ASSERT_NEXT(a_resp, clk, rst, s_tvalid && s_tready, m_tvalid)

  // plain bytes never touch the stack
  `MTNT_ASSERT_IMPLY(a_plain, clk, rst, m_tvalid && !m_tlast, r.action == ACT_NONE && r.tag_kind == KIND_OTHER)

  // a tag end always reports some action
  `MTNT_ASSERT_IMPLY(a_tagact, clk, rst, m_tvalid && m_tlast, r.action != ACT_NONE)

  // empty stack shows no top kind
  `MTNT_ASSERT_IMPLY(a_empty, clk, rst, m_tvalid && r.depth == '0, r.top_kind == KIND_OTHER)

endmodule

bind markup_tag_nesting_tracker_unit mtnt_checker u_mtnt_checker (.*);
